// ===== hdl/sbpp_pkg.sv =====
// Shared types and constants for the sphere broad phase pair search.
`default_nettype none
package sbpp_pkg;

	localparam int IDX_BITS       = 4;
	localparam int OUT_FIELD_BITS = 2 * IDX_BITS + 1;
	localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

	typedef struct packed {
		logic valid;
		logic closing;
		logic ovf;
	} tag_t;

endpackage
`default_nettype wire

// ===== hdl/sbpp_mem.sv =====
// Sphere store: one write port, one registered read port.
`default_nettype none
module sbpp_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 95
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/sbpp_test.sv =====
// Overlap test pipeline: differences, squares, distance sum, compare.
`default_nettype none
module sbpp_test import sbpp_pkg::*; #(
	parameter int COORD_BITS = 24,
	parameter int AW         = 4
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    adv,
	input  wire tag_t                    tag_s1,
	input  wire logic [AW-1:0]           idx_s1,
	input  wire logic [4*COORD_BITS-2:0] rd_s1,
	input  wire logic [4*COORD_BITS-2:0] sph_q,
	output tag_t                         tag_s4,
	output logic      [AW-1:0]           idx_s4,
	output logic                         hit
);

	localparam int C    = COORD_BITS;
	localparam int DW   = C + 1;
	localparam int SQW  = 2 * C + 2;
	localparam int RSQW = 2 * C;
	localparam int SUMW = 2 * C + 3;

	function automatic logic [DW-1:0] abs_diff(input logic [C-1:0] a, input logic [C-1:0] b);
		logic [DW-1:0] d;
		d = {a[C-1], a} - {b[C-1], b};
		return d[DW-1] ? (~d + DW'(1)) : d;
	endfunction

	tag_t            tag_s2, tag_s3;
	logic [AW-1:0]   idx_s2, idx_s3;
	logic [DW-1:0]   dx_s2, dy_s2, dz_s2;
	logic [C-1:0]    rs_s2;
	logic [SQW-1:0]  sqx_s3, sqy_s3, sqz_s3;
	logic [RSQW-1:0] rsq_s3, rsq_s4;
	logic [SUMW-1:0] sum_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else if (adv) begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s2 <= idx_s1;
			dx_s2  <= abs_diff(sph_q[C-1:0], rd_s1[C-1:0]);
			dy_s2  <= abs_diff(sph_q[2*C-1:C], rd_s1[2*C-1:C]);
			dz_s2  <= abs_diff(sph_q[3*C-1:2*C], rd_s1[3*C-1:2*C]);
			rs_s2  <= C'(sph_q[4*C-2:3*C]) + C'(rd_s1[4*C-2:3*C]);

			idx_s3 <= idx_s2;
			sqx_s3 <= SQW'(dx_s2) * SQW'(dx_s2);
			sqy_s3 <= SQW'(dy_s2) * SQW'(dy_s2);
			sqz_s3 <= SQW'(dz_s2) * SQW'(dz_s2);
			rsq_s3 <= RSQW'(rs_s2) * RSQW'(rs_s2);

			idx_s4 <= idx_s3;
			sum_s4 <= SUMW'(sqx_s3) + SUMW'(sqy_s3) + SUMW'(sqz_s3);
			rsq_s4 <= rsq_s3;
		end
	end

	assign hit = sum_s4 <= SUMW'(rsq_s4);

endmodule
`default_nettype wire

// ===== hdl/sphere_broad_phase_pairs.sv =====
// Top level: sphere intake, store sequencing and result output register.
//
// Input channel s_*: one sphere per item. s_tdata holds pos_x, pos_y, pos_z
// (COORD_BITS each, signed) and radius (COORD_BITS-1, unsigned) from bit 0 up;
// s_tuser is the first flag, which empties the store and opens a new frame.
// Output channel m_*: for each stored sphere that overlaps the new one, a pair
// item (m_tuser = 1) in ascending earlier index, then one closing item with
// m_tlast = 1. A sphere that arrives with the store full is dropped and only
// a closing item with overflow set is returned.
// Scanning: the store is a one-port-read memory scanned one entry per cycle
// while m_tready does not stall; each item is compared against the stored
// spheres (none when it opens a frame or is dropped). One item is handled
// at a time: s_tready is high only once the closing item of the previous
// one was taken. A stall on m_tready freezes the scan and compare
// pipeline in place. Reset empties the store (count to zero) and drops any
// item in flight; the memory contents are not cleared.
`default_nettype none
module sphere_broad_phase_pairs import sbpp_pkg::*; #(
	parameter int MAX_SPHERES = 16,
	parameter int COORD_BITS  = 24
) (
	input  wire logic                                        clk,
	input  wire logic                                        arst_n,
	input  wire logic                                        s_tvalid,
	output logic                                             s_tready,
	// pos_x, pos_y, pos_z, radius, zero pad
	input  wire logic [((4*COORD_BITS-1+7)/8)*8-1:0]         s_tdata,
	// first
	input  wire logic                                        s_tuser,
	output logic                                             m_tvalid,
	input  wire logic                                        m_tready,
	// earlier_index, new_index, overflow, zero pad
	output logic      [OUT_DATA_BITS-1:0]                    m_tdata,
	// has_pair
	output logic                                             m_tuser,
	output logic                                             m_tlast
);

	localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
	localparam int CW = $clog2(MAX_SPHERES + 1);
	localparam int WW = 4 * COORD_BITS - 1;

	typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   cnt_eff;
	logic            full;
	logic            accept;
	logic            adv;
	logic [WW-1:0]   sph_q;
	logic [AW-1:0]   nidx_q;
	logic            novf_q;
	logic [AW-1:0]   rd_i_q;
	tag_t            tag_s1;
	logic [AW-1:0]   idx_s1;
	logic [WW-1:0]   rd_s1;
	tag_t            tag_s4;
	logic [AW-1:0]   idx_s4;
	logic            hit;
	logic            out_v_q;
	logic            pair_q;
	logic            last_q;
	logic            ovf_q;
	logic [IDX_BITS-1:0] eidx_q;
	logic [IDX_BITS-1:0] nidx_out_q;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign cnt_eff  = s_tuser ? '0 : count_q;
	assign full     = (cnt_eff == CW'(MAX_SPHERES));
	assign adv      = !out_v_q || m_tready;

	sbpp_mem #(
		.DEPTH (MAX_SPHERES),
		.WIDTH (WW)
	) u_mem (
		.clk   (clk),
		.we    (accept && !full),
		.waddr (cnt_eff[AW-1:0]),
		.wdata (s_tdata[WW-1:0]),
		.re    (adv),
		.raddr (rd_i_q),
		.rdata (rd_s1)
	);

	sbpp_test #(
		.COORD_BITS (COORD_BITS),
		.AW         (AW)
	) u_test (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.tag_s1 (tag_s1),
		.idx_s1 (idx_s1),
		.rd_s1  (rd_s1),
		.sph_q  (sph_q),
		.tag_s4 (tag_s4),
		.idx_s4 (idx_s4),
		.hit    (hit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rd_i_q  <= '0;
			tag_s1  <= '0;
			out_v_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= full ? count_q : cnt_eff + CW'(1);
						rd_i_q  <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (adv) begin
						if (!novf_q && rd_i_q != nidx_q) begin
							tag_s1 <= '{valid: 1'b1, closing: 1'b0, ovf: 1'b0};
							idx_s1 <= rd_i_q;
							rd_i_q <= rd_i_q + AW'(1);
						end else begin
							tag_s1  <= '{valid: 1'b1, closing: 1'b1, ovf: novf_q};
							idx_s1  <= '0;
							state_q <= ST_WAIT;
						end
					end
				end
				ST_WAIT: begin
					if (adv) begin
						tag_s1 <= '0;
					end
					if (out_v_q && m_tready && last_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (adv) begin
				out_v_q <= tag_s4.valid && (tag_s4.closing || hit);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sph_q  <= s_tdata[WW-1:0];
			novf_q <= full;
			nidx_q <= full ? '0 : cnt_eff[AW-1:0];
		end
		if (adv) begin
			pair_q     <= !tag_s4.closing;
			last_q     <= tag_s4.closing;
			ovf_q      <= tag_s4.closing && tag_s4.ovf;
			eidx_q     <= tag_s4.closing ? '0 : IDX_BITS'(idx_s4);
			nidx_out_q <= IDX_BITS'(nidx_q);
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = pair_q;
	assign m_tlast  = last_q;
	assign m_tdata  = {{(OUT_DATA_BITS - OUT_FIELD_BITS){1'b0}}, ovf_q, nidx_out_q, eidx_q};

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !out_v_q && !tag_s1.valid)
		else $error("output or scan busy while idle");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SPHERES))
		else $error("sphere count beyond capacity");

	a_read_below: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s1.valid && !tag_s1.closing |-> idx_s1 < nidx_q && !novf_q)
		else $error("store read at or above the new sphere index");

endmodule
`default_nettype wire

// ===== sim/sphere_broad_phase_pairs_tb.sv =====
`timescale 1ns / 100ps
// Testbench for sphere_broad_phase_pairs: sphere frames checked against an overlap predictor.
module sphere_broad_phase_pairs_tb import sbpp_pkg::*;;

	localparam int MAX_SPHERES  = 16;
	localparam int COORD_BITS   = 24;
	localparam int S_DATA_BITS  = ((4*COORD_BITS-1+7)/8)*8;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;

	localparam logic [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic [COORD_BITS-2:0] R_MAX = '1;

	typedef struct packed {
		logic                  first;
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [COORD_BITS-1:0] z;
		logic [COORD_BITS-2:0] r;
	} sphere_t;

	typedef struct packed {
		logic                has_pair;
		logic [IDX_BITS-1:0] earlier;
		logic [IDX_BITS-1:0] newer;
		logic                ovf;
		logic                closing;
	} pair_report_t;

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [S_DATA_BITS-1:0] s_tdata  = '0;
	logic                   s_tuser  = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_BITS-1:0] m_tdata;
	logic                   m_tuser;
	logic                   m_tlast;

	logic [COORD_BITS-1:0] held_x [MAX_SPHERES];
	logic [COORD_BITS-1:0] held_y [MAX_SPHERES];
	logic [COORD_BITS-1:0] held_z [MAX_SPHERES];
	logic [COORD_BITS-2:0] held_r [MAX_SPHERES];
	int unsigned held_count = 0;

	pair_report_t due_reports [$];

	int errors      = 0;
	int items_sent  = 0;
	int frames_sent = 0;
	int pairs_seen  = 0;
	int drops_seen  = 0;
	int cycles      = 0;
	bit calm        = 1'b0;

	sphere_broad_phase_pairs #(
		.MAX_SPHERES(MAX_SPHERES),
		.COORD_BITS (COORD_BITS)
	) uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.m_tlast (m_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(negedge clk) begin
		m_tready <= calm || ($urandom_range(0, 99) >= 10);
	end

	task automatic report_mismatch(input string msg);
		if (errors < 40)
			$display("MISMATCH cycle %0d: %s", cycles, msg);
		errors++;
	endtask

	// expected results for one sphere, grouped by the new sphere
	function automatic void predict_overlaps(input sphere_t sp);
		int unsigned idx;
		longint dx, dy, dz, d2, rs;
		if (sp.first)
			held_count = 0;
		if (held_count >= MAX_SPHERES) begin
			due_reports.push_back(pair_report_t'{1'b0, '0, '0, 1'b1, 1'b1});
			return;
		end
		idx = held_count;
		for (int i = 0; i < idx; i++) begin
			dx = longint'($signed(sp.x)) - longint'($signed(held_x[i]));
			dy = longint'($signed(sp.y)) - longint'($signed(held_y[i]));
			dz = longint'($signed(sp.z)) - longint'($signed(held_z[i]));
			d2 = dx*dx + dy*dy + dz*dz;
			rs = longint'(sp.r) + longint'(held_r[i]);
			if (d2 <= rs*rs)
				due_reports.push_back(pair_report_t'{1'b1, IDX_BITS'(i), IDX_BITS'(idx),
					1'b0, 1'b0});
		end
		held_x[idx] = sp.x;
		held_y[idx] = sp.y;
		held_z[idx] = sp.z;
		held_r[idx] = sp.r;
		held_count = idx + 1;
		due_reports.push_back(pair_report_t'{1'b0, '0, IDX_BITS'(idx), 1'b0, 1'b1});
	endfunction

	always @(posedge clk) begin : check_results
		pair_report_t got, want;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[IDX_BITS-1:0], m_tdata[2*IDX_BITS-1:IDX_BITS],
				m_tdata[2*IDX_BITS], m_tlast};
			if (got.has_pair)
				pairs_seen++;
			if (got.ovf)
				drops_seen++;
			if (due_reports.size() == 0) begin
				report_mismatch($sformatf("unexpected result %p", got));
			end else begin
				want = due_reports.pop_front();
				if (got.has_pair != want.has_pair)
					report_mismatch($sformatf("has_pair %0b, want %0b", got.has_pair,
						want.has_pair));
				if (got.earlier != want.earlier)
					report_mismatch($sformatf("earlier_index %0d, want %0d", got.earlier,
						want.earlier));
				if (got.newer != want.newer)
					report_mismatch($sformatf("new_index %0d, want %0d", got.newer,
						want.newer));
				if (got.ovf != want.ovf)
					report_mismatch($sformatf("overflow %0b, want %0b", got.ovf, want.ovf));
				if (got.closing != want.closing)
					report_mismatch($sformatf("last %0b, want %0b", got.closing,
						want.closing));
			end
		end
	end

	task automatic send_sphere(input sphere_t sp);
		@(negedge clk);
		while (!calm && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= sp.first;
		s_tdata  <= S_DATA_BITS'({sp.r, sp.z, sp.y, sp.x});
		do @(posedge clk); while (!s_tready);
		predict_overlaps(sp);
		items_sent++;
		if (sp.first)
			frames_sent++;
	endtask

	function automatic sphere_t wide_sphere(input bit first);
		sphere_t sp;
		sp.first = first;
		sp.x     = COORD_BITS'($urandom());
		sp.y     = COORD_BITS'($urandom());
		sp.z     = COORD_BITS'($urandom());
		sp.r     = (COORD_BITS-1)'($urandom());
		return sp;
	endfunction

	// spread of 2^s around a base, radii up to 2^s: plenty of overlaps
	function automatic sphere_t cluster_sphere(input bit first, input int bx, input int by,
		input int bz, input int s);
		sphere_t sp;
		sp.first = first;
		sp.x     = COORD_BITS'(bx + int'($urandom_range(0, 2**(s+1))) - 2**s);
		sp.y     = COORD_BITS'(by + int'($urandom_range(0, 2**(s+1))) - 2**s);
		sp.z     = COORD_BITS'(bz + int'($urandom_range(0, 2**(s+1))) - 2**s);
		sp.r     = (COORD_BITS-1)'($urandom_range(0, 2**s));
		return sp;
	endfunction

	task automatic test_directed();
		// no first flag yet: implicit frame
		send_sphere(sphere_t'{1'b0, 24'd0, 24'd0, 24'd0, 23'd0});
		// same center, both radii zero
		send_sphere(sphere_t'{1'b0, 24'd0, 24'd0, 24'd0, 23'd0});
		// distance exactly equal to the radius sum
		send_sphere(sphere_t'{1'b0, 24'd3, 24'd4, 24'd0, 23'd5});
		send_sphere(sphere_t'{1'b0, 24'd0, 24'd0, 24'd6, 23'd5});
		send_sphere(sphere_t'{1'b0, C_MAX, C_MIN, C_MAX, R_MAX});
		send_sphere(sphere_t'{1'b0, C_MIN, C_MAX, C_MIN, R_MAX});
		// full frame of mutually overlapping spheres, then two dropped
		for (int i = 0; i < MAX_SPHERES; i++)
			send_sphere(sphere_t'{i == 0, C_MIN + COORD_BITS'(i), 24'd0,
				C_MAX - COORD_BITS'(i), R_MAX});
		send_sphere(wide_sphere(1'b0));
		send_sphere(sphere_t'{1'b0, C_MIN, C_MIN, C_MIN, 23'd0});
	endtask

	task automatic test_random_frames(input int n);
		int sent, len, s, bx, by, bz;
		sent = 0;
		while (sent < n) begin
			len = ($urandom_range(0, 5) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 10);
			s   = 3 + 6 * $urandom_range(0, 3);
			bx  = int'($urandom_range(0, 2**23)) - 2**22;
			by  = int'($urandom_range(0, 2**23)) - 2**22;
			bz  = int'($urandom_range(0, 2**23)) - 2**22;
			for (int k = 0; k < len && sent < n; k++) begin
				if ($urandom_range(0, 9) == 0)
					send_sphere(wide_sphere(k == 0));
				else
					send_sphere(cluster_sphere(k == 0, bx, by, bz, s));
				sent++;
			end
		end
	endtask

	task automatic test_no_idle(input int n);
		calm = 1'b1;
		test_random_frames(n);
		calm = 1'b0;
	endtask

	task automatic test_full_range(input int n);
		for (int i = 0; i < n; i++)
			send_sphere(wide_sphere($urandom_range(0, 11) == 0));
	endtask

	initial begin
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_frames(250);
		test_no_idle(80);
		test_full_range(60);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d spheres, %0d flagged frames, %0d overlap pairs, %0d dropped.",
			items_sent, frames_sent, pairs_seen, drops_seen);
		$display("Field mismatches or stray results: %0d", errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
